// ===== hdl/mos6502_execute_unit_assert.svh =====
// ============================================================================
// mos6502_execute_unit assertion macros
// Property wrappers used by the execute unit; NO_ASSERTIONS removes them.
// ============================================================================
`ifndef MOS6502_EXECUTE_UNIT_ASSERT_SVH
`define MOS6502_EXECUTE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the unit clock outside reset.
`define M65X_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("execute unit check failed");
// Next-cycle implication, sampled on the unit clock outside reset.
`define M65X_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("execute unit check failed");
`else
`define M65X_ASSERT_NOW(lbl, ante, cons)
`define M65X_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/m65x_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// m65x_pkg
// Shared types and constants of the 6502 execute unit.
// ============================================================================
package m65x_pkg;

    localparam int STACK_DEPTH_DEF = 256;

    // Status register bit positions.
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] FLAGS_RESET = 8'h20;
    localparam logic [7:0] SP_RESET    = 8'hFF;

    typedef enum logic [5:0] {
        CMD_NOP = 6'd0,  CMD_LDA = 6'd1,  CMD_LDX = 6'd2,  CMD_LDY = 6'd3,
        CMD_STA = 6'd4,  CMD_STX = 6'd5,  CMD_STY = 6'd6,  CMD_TAX = 6'd7,
        CMD_TXA = 6'd8,  CMD_TAY = 6'd9,  CMD_TYA = 6'd10, CMD_TSX = 6'd11,
        CMD_TXS = 6'd12, CMD_PHA = 6'd13, CMD_PLA = 6'd14, CMD_PHP = 6'd15,
        CMD_PLP = 6'd16, CMD_CLC = 6'd17, CMD_SEC = 6'd18, CMD_CLI = 6'd19,
        CMD_SEI = 6'd20, CMD_CLV = 6'd21, CMD_CLD = 6'd22, CMD_SED = 6'd23,
        CMD_INX = 6'd24, CMD_INY = 6'd25, CMD_DEX = 6'd26, CMD_DEY = 6'd27,
        CMD_INC = 6'd28, CMD_DEC = 6'd29, CMD_AND = 6'd30, CMD_ORA = 6'd31,
        CMD_EOR = 6'd32, CMD_ADC = 6'd33, CMD_SBC = 6'd34, CMD_ASLA = 6'd35,
        CMD_ASLM = 6'd36, CMD_LSRA = 6'd37, CMD_LSRM = 6'd38, CMD_ROLA = 6'd39,
        CMD_ROLM = 6'd40, CMD_RORA = 6'd41, CMD_RORM = 6'd42, CMD_CMP = 6'd43,
        CMD_CPX = 6'd44, CMD_CPY = 6'd45, CMD_BIT = 6'd46, CMD_BCC = 6'd47,
        CMD_BCS = 6'd48, CMD_BEQ = 6'd49, CMD_BNE = 6'd50, CMD_BMI = 6'd51,
        CMD_BPL = 6'd52, CMD_BVC = 6'd53, CMD_BVS = 6'd54, CMD_JMP = 6'd55,
        CMD_JSR = 6'd56, CMD_RTS = 6'd57
    } t_cmd;

    typedef struct packed {
        logic [5:0]  command;
        logic [7:0]  operand_value;
        logic [15:0] operand_address;
        logic [1:0]  instr_length;
    } t_in_word;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [7:0]  accumulator;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  stack_pointer;
        logic [15:0] program_counter;
        logic [7:0]  status_flags;
    } t_out_word;

endpackage
`default_nettype wire

// ===== hdl/mos6502_execute_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mos6502_execute_unit
// Executes one decoded 6502 instruction per accepted word.
// ============================================================================
// Each accepted word runs in the cycle it is accepted and its result word is
// held in an output register, so a new word is taken every cycle while the
// output side keeps up. The stack lives in two RAM banks (even and odd
// entries) so JSR can push two bytes and RTS pop two in the same cycle; the
// next two stack entries above the new stack pointer are read ahead at every
// edge, with writes of the same edge forwarded. STACK_DEPTH must be a power
// of two; stack entries read as zero until written, and no clearing pass
// is needed after reset.
module mos6502_execute_unit #(
    parameter int STACK_DEPTH = m65x_pkg::STACK_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire m65x_pkg::t_in_word i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output m65x_pkg::t_out_word     o_out_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int BANK_DEPTH = STACK_DEPTH / 2;

    // Architectural state.
    logic [7:0]  r_a, r_x, r_y, r_sp, r_p;
    logic [15:0] r_pc;
    logic [7:0]  n_a, n_x, n_y, n_sp, n_p;
    logic [15:0] n_pc;

    logic                r_out_valid;
    m65x_pkg::t_out_word r_out;
    m65x_pkg::t_out_word n_out;

    logic accept;

    // Stack bank signals.
    logic [STACK_DEPTH-1:0] r_vld;
    logic [7:0]   bank_q    [2];
    logic [7:0]   bank_val  [2];
    logic         r_hit     [2];
    logic [7:0]   r_hit_dat [2];
    logic         r_rvld    [2];
    logic         r_top1_bank;
    logic         bank_we   [2];
    logic [AW-1:0] bank_widx [2];
    logic [7:0]   bank_wdat [2];
    logic [AW-1:0] bank_ridx [2];
    logic [7:0]   top1, top2;

    logic         push_a_en, push_b_en;
    logic [7:0]   push_a_dat, push_b_dat;
    logic [AW-1:0] idx_a, idx_b;
    logic [7:0]   sp_eff, rs1, rs2;

    function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q = p;
        q[m65x_pkg::FLAG_Z] = (v == 8'd0);
        q[m65x_pkg::FLAG_N] = v[7];
        return q;
    endfunction

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Bank read values: forwarded write, stored entry, or zero if never written.
    always_comb begin
        for (int b = 0; b < 2; b++) begin
            if (r_hit[b]) begin
                bank_val[b] = r_hit_dat[b];
            end else if (r_rvld[b]) begin
                bank_val[b] = bank_q[b];
            end else begin
                bank_val[b] = 8'd0;
            end
        end
        top1 = r_top1_bank ? bank_val[1] : bank_val[0];
        top2 = r_top1_bank ? bank_val[0] : bank_val[1];
    end

    // Execute.
    always_comb begin
        logic [8:0]  sum;
        logic [7:0]  opnd;
        logic [7:0]  res;
        logic [8:0]  diff;
        logic [7:0]  cmp_reg;
        logic [15:0] pc_len;
        logic [15:0] ret;
        logic        take;
        logic        cin;
        m65x_pkg::t_cmd cmd;

        cmd     = m65x_pkg::t_cmd'(i_in_data.command);
        pc_len  = r_pc + {14'd0, i_in_data.instr_length};
        ret     = pc_len - 16'd1;
        cin     = r_p[m65x_pkg::FLAG_C];
        opnd    = (cmd == m65x_pkg::CMD_SBC) ? ~i_in_data.operand_value
                                             : i_in_data.operand_value;
        sum     = {1'b0, r_a} + {1'b0, opnd} + {8'd0, cin};
        cmp_reg = r_a;
        res     = 8'd0;
        diff    = 9'd0;
        take    = 1'b0;

        n_a = r_a; n_x = r_x; n_y = r_y; n_sp = r_sp; n_p = r_p; n_pc = pc_len;
        n_out = '0;
        push_a_en = 1'b0; push_a_dat = 8'd0;
        push_b_en = 1'b0; push_b_dat = 8'd0;

        case (cmd)
            m65x_pkg::CMD_LDA: begin n_a = i_in_data.operand_value; n_p = nz(r_p, n_a); end
            m65x_pkg::CMD_LDX: begin n_x = i_in_data.operand_value; n_p = nz(r_p, n_x); end
            m65x_pkg::CMD_LDY: begin n_y = i_in_data.operand_value; n_p = nz(r_p, n_y); end
            m65x_pkg::CMD_STA: begin n_out.write_enable = 1'b1; n_out.write_data = r_a; end
            m65x_pkg::CMD_STX: begin n_out.write_enable = 1'b1; n_out.write_data = r_x; end
            m65x_pkg::CMD_STY: begin n_out.write_enable = 1'b1; n_out.write_data = r_y; end
            m65x_pkg::CMD_TAX: begin n_x = r_a; n_p = nz(r_p, r_a); end
            m65x_pkg::CMD_TXA: begin n_a = r_x; n_p = nz(r_p, r_x); end
            m65x_pkg::CMD_TAY: begin n_y = r_a; n_p = nz(r_p, r_a); end
            m65x_pkg::CMD_TYA: begin n_a = r_y; n_p = nz(r_p, r_y); end
            m65x_pkg::CMD_TSX: begin n_x = r_sp; n_p = nz(r_p, r_sp); end
            m65x_pkg::CMD_TXS: n_sp = r_x;
            m65x_pkg::CMD_PHA: begin
                push_a_en = 1'b1; push_a_dat = r_a; n_sp = r_sp - 8'd1;
            end
            m65x_pkg::CMD_PLA: begin
                n_sp = r_sp + 8'd1; n_a = top1; n_p = nz(r_p, top1);
            end
            m65x_pkg::CMD_PHP: begin
                push_a_en = 1'b1;
                push_a_dat = r_p | 8'h30;
                n_sp = r_sp - 8'd1;
            end
            m65x_pkg::CMD_PLP: begin
                n_sp = r_sp + 8'd1;
                n_p = top1;
                n_p[m65x_pkg::FLAG_B] = 1'b0;
                n_p[m65x_pkg::FLAG_U] = 1'b1;
            end
            m65x_pkg::CMD_CLC: n_p[m65x_pkg::FLAG_C] = 1'b0;
            m65x_pkg::CMD_SEC: n_p[m65x_pkg::FLAG_C] = 1'b1;
            m65x_pkg::CMD_CLI: n_p[m65x_pkg::FLAG_I] = 1'b0;
            m65x_pkg::CMD_SEI: n_p[m65x_pkg::FLAG_I] = 1'b1;
            m65x_pkg::CMD_CLV: n_p[m65x_pkg::FLAG_V] = 1'b0;
            m65x_pkg::CMD_CLD: n_p[m65x_pkg::FLAG_D] = 1'b0;
            m65x_pkg::CMD_SED: n_p[m65x_pkg::FLAG_D] = 1'b1;
            m65x_pkg::CMD_INX: begin n_x = r_x + 8'd1; n_p = nz(r_p, n_x); end
            m65x_pkg::CMD_INY: begin n_y = r_y + 8'd1; n_p = nz(r_p, n_y); end
            m65x_pkg::CMD_DEX: begin n_x = r_x - 8'd1; n_p = nz(r_p, n_x); end
            m65x_pkg::CMD_DEY: begin n_y = r_y - 8'd1; n_p = nz(r_p, n_y); end
            m65x_pkg::CMD_INC: begin
                res = i_in_data.operand_value + 8'd1;
                n_out.write_enable = 1'b1; n_out.write_data = res; n_p = nz(r_p, res);
            end
            m65x_pkg::CMD_DEC: begin
                res = i_in_data.operand_value - 8'd1;
                n_out.write_enable = 1'b1; n_out.write_data = res; n_p = nz(r_p, res);
            end
            m65x_pkg::CMD_AND: begin
                n_a = r_a & i_in_data.operand_value; n_p = nz(r_p, n_a);
            end
            m65x_pkg::CMD_ORA: begin
                n_a = r_a | i_in_data.operand_value; n_p = nz(r_p, n_a);
            end
            m65x_pkg::CMD_EOR: begin
                n_a = r_a ^ i_in_data.operand_value; n_p = nz(r_p, n_a);
            end
            m65x_pkg::CMD_ADC, m65x_pkg::CMD_SBC: begin
                n_a = sum[7:0];
                n_p = nz(r_p, sum[7:0]);
                n_p[m65x_pkg::FLAG_C] = sum[8];
                n_p[m65x_pkg::FLAG_V] = ~(r_a[7] ^ opnd[7]) & (r_a[7] ^ sum[7]);
            end
            m65x_pkg::CMD_ASLA: begin
                res = {r_a[6:0], 1'b0}; n_a = res;
                n_p = nz(r_p, res); n_p[m65x_pkg::FLAG_C] = r_a[7];
            end
            m65x_pkg::CMD_LSRA: begin
                res = {1'b0, r_a[7:1]}; n_a = res;
                n_p = nz(r_p, res); n_p[m65x_pkg::FLAG_C] = r_a[0];
            end
            m65x_pkg::CMD_ROLA: begin
                res = {r_a[6:0], cin}; n_a = res;
                n_p = nz(r_p, res); n_p[m65x_pkg::FLAG_C] = r_a[7];
            end
            m65x_pkg::CMD_RORA: begin
                res = {cin, r_a[7:1]}; n_a = res;
                n_p = nz(r_p, res); n_p[m65x_pkg::FLAG_C] = r_a[0];
            end
            m65x_pkg::CMD_ASLM: begin
                res = {i_in_data.operand_value[6:0], 1'b0};
                n_out.write_enable = 1'b1; n_out.write_data = res;
                n_p = nz(r_p, res); n_p[m65x_pkg::FLAG_C] = i_in_data.operand_value[7];
            end
            m65x_pkg::CMD_LSRM: begin
                res = {1'b0, i_in_data.operand_value[7:1]};
                n_out.write_enable = 1'b1; n_out.write_data = res;
                n_p = nz(r_p, res); n_p[m65x_pkg::FLAG_C] = i_in_data.operand_value[0];
            end
            m65x_pkg::CMD_ROLM: begin
                res = {i_in_data.operand_value[6:0], cin};
                n_out.write_enable = 1'b1; n_out.write_data = res;
                n_p = nz(r_p, res); n_p[m65x_pkg::FLAG_C] = i_in_data.operand_value[7];
            end
            m65x_pkg::CMD_RORM: begin
                res = {cin, i_in_data.operand_value[7:1]};
                n_out.write_enable = 1'b1; n_out.write_data = res;
                n_p = nz(r_p, res); n_p[m65x_pkg::FLAG_C] = i_in_data.operand_value[0];
            end
            m65x_pkg::CMD_CMP, m65x_pkg::CMD_CPX, m65x_pkg::CMD_CPY: begin
                if (cmd == m65x_pkg::CMD_CPX) begin
                    cmp_reg = r_x;
                end else if (cmd == m65x_pkg::CMD_CPY) begin
                    cmp_reg = r_y;
                end
                diff = {1'b0, cmp_reg} - {1'b0, i_in_data.operand_value};
                n_p[m65x_pkg::FLAG_C] = !diff[8];
                n_p[m65x_pkg::FLAG_Z] = (cmp_reg == i_in_data.operand_value);
                n_p[m65x_pkg::FLAG_N] = diff[7];
            end
            m65x_pkg::CMD_BIT: begin
                n_p[m65x_pkg::FLAG_N] = i_in_data.operand_value[7];
                n_p[m65x_pkg::FLAG_V] = i_in_data.operand_value[6];
                n_p[m65x_pkg::FLAG_Z] = ((i_in_data.operand_value & r_a) == 8'd0);
            end
            m65x_pkg::CMD_BCC: take = !r_p[m65x_pkg::FLAG_C];
            m65x_pkg::CMD_BCS: take =  r_p[m65x_pkg::FLAG_C];
            m65x_pkg::CMD_BEQ: take =  r_p[m65x_pkg::FLAG_Z];
            m65x_pkg::CMD_BNE: take = !r_p[m65x_pkg::FLAG_Z];
            m65x_pkg::CMD_BMI: take =  r_p[m65x_pkg::FLAG_N];
            m65x_pkg::CMD_BPL: take = !r_p[m65x_pkg::FLAG_N];
            m65x_pkg::CMD_BVC: take = !r_p[m65x_pkg::FLAG_V];
            m65x_pkg::CMD_BVS: take =  r_p[m65x_pkg::FLAG_V];
            m65x_pkg::CMD_JMP: n_pc = i_in_data.operand_address;
            m65x_pkg::CMD_JSR: begin
                push_a_en = 1'b1; push_a_dat = ret[15:8];
                push_b_en = 1'b1; push_b_dat = ret[7:0];
                n_sp = r_sp - 8'd2;
                n_pc = i_in_data.operand_address;
            end
            m65x_pkg::CMD_RTS: begin
                n_sp = r_sp + 8'd2;
                n_pc = {top2, top1} + 16'd1;
            end
            default: ;
        endcase

        if (take) begin
            n_pc = pc_len + {{8{i_in_data.operand_value[7]}}, i_in_data.operand_value};
        end

        if (n_out.write_enable) begin
            n_out.write_address = i_in_data.operand_address;
        end
        n_out.accumulator     = n_a;
        n_out.index_x         = n_x;
        n_out.index_y         = n_y;
        n_out.stack_pointer   = n_sp;
        n_out.program_counter = n_pc;
        n_out.status_flags    = n_p;
    end

    // Stack bank write and read-ahead addressing.
    always_comb begin
        idx_a  = r_sp[AW-1:0];
        idx_b  = idx_a - {{(AW-1){1'b0}}, 1'b1};
        sp_eff = accept ? n_sp : r_sp;
        rs1    = sp_eff + 8'd1;
        rs2    = sp_eff + 8'd2;
        for (int b = 0; b < 2; b++) begin
            bank_we[b]   = 1'b0;
            bank_widx[b] = idx_a;
            bank_wdat[b] = push_a_dat;
            if (accept && push_a_en && (idx_a[0] == b[0])) begin
                bank_we[b] = 1'b1;
            end else if (accept && push_b_en && (idx_b[0] == b[0])) begin
                bank_we[b]   = 1'b1;
                bank_widx[b] = idx_b;
                bank_wdat[b] = push_b_dat;
            end
            bank_ridx[b] = (rs1[0] == b[0]) ? rs1[AW-1:0] : rs2[AW-1:0];
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_bank
        m65x_ram #(
            .WIDTH(8),
            .DEPTH(BANK_DEPTH)
        ) u_bank (
            .i_clk  (i_clk),
            .i_we   (bank_we[g]),
            .i_waddr(bank_widx[g][AW-1:1]),
            .i_wdata(bank_wdat[g]),
            .i_raddr(bank_ridx[g][AW-1:1]),
            .o_rdata(bank_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= 8'd0;
            r_x         <= 8'd0;
            r_y         <= 8'd0;
            r_sp        <= m65x_pkg::SP_RESET;
            r_pc        <= 16'd0;
            r_p         <= m65x_pkg::FLAGS_RESET;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_top1_bank <= 1'b0;
            for (int b = 0; b < 2; b++) begin
                r_hit[b]  <= 1'b0;
                r_rvld[b] <= 1'b0;
            end
        end else begin
            if (accept) begin
                r_a  <= n_a;
                r_x  <= n_x;
                r_y  <= n_y;
                r_sp <= n_sp;
                r_pc <= n_pc;
                r_p  <= n_p;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_top1_bank <= rs1[0];
            for (int b = 0; b < 2; b++) begin
                if (bank_we[b]) begin
                    r_vld[bank_widx[b]] <= 1'b1;
                end
                r_hit[b]  <= bank_we[b] && (bank_widx[b] == bank_ridx[b]);
                r_rvld[b] <= r_vld[bank_ridx[b]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
        for (int b = 0; b < 2; b++) begin
            r_hit_dat[b] <= bank_wdat[b];
        end
    end

`include "mos6502_execute_unit_assert.svh"

    // The shown result always matches the live register file.
    `M65X_ASSERT_NOW(a_out_tracks_state, r_out_valid, (r_out.stack_pointer == r_sp) && (r_out.program_counter == r_pc) && (r_out.accumulator == r_a))
    // A single-byte push moves the stack pointer down by one.
    `M65X_ASSERT_NEXT(a_push_sp, accept && push_a_en && !push_b_en, r_sp == $past(r_sp) - 8'd1)
    // Input is held off only while a result waits.
    `M65X_ASSERT_NOW(a_ready_hold, !o_in_ready, r_out_valid)
    // The unused status bit stays set.
    `M65X_ASSERT_NOW(a_unused_flag, 1'b1, r_p[m65x_pkg::FLAG_U])

endmodule
`default_nettype wire

// ===== hdl/m65x_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// m65x_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module m65x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== tb/mos6502_execute_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mos6502_execute_unit_tb
// Drives decoded 6502 instructions into the execute unit and checks every
// result word against a cycle-free model of the registers, flags and stack.
// ============================================================================

class exec_scoreboard;
    logic [7:0]  a_q, x_q, y_q, sp_q, p_q;
    logic [15:0] pc_q;
    logic [7:0]  stk[256];
    m65x_pkg::t_out_word pending[$];
    int          n_err;

    function void clear();
        a_q = 8'h00; x_q = 8'h00; y_q = 8'h00;
        sp_q = m65x_pkg::SP_RESET; p_q = m65x_pkg::FLAGS_RESET; pc_q = 16'h0000;
        foreach (stk[i]) stk[i] = 8'h00;
        pending.delete();
        n_err = 0;
    endfunction

    function void put_nz(logic [7:0] v);
        p_q[m65x_pkg::FLAG_Z] = (v == 8'h00);
        p_q[m65x_pkg::FLAG_N] = v[7];
    endfunction

    function void push(logic [7:0] v);
        stk[sp_q] = v;
        sp_q = sp_q - 8'd1;
    endfunction

    function logic [7:0] pop();
        sp_q = sp_q + 8'd1;
        return stk[sp_q];
    endfunction

    function void add_with_carry(logic [7:0] v);
        logic [8:0] s;
        s = {1'b0, a_q} + {1'b0, v} + {8'h00, p_q[m65x_pkg::FLAG_C]};
        p_q[m65x_pkg::FLAG_C] = s[8];
        p_q[m65x_pkg::FLAG_V] = ~(a_q[7] ^ v[7]) & (a_q[7] ^ s[7]);
        a_q = s[7:0];
        put_nz(a_q);
    endfunction

    function void compare(logic [7:0] r, logic [7:0] v);
        logic [7:0] d;
        d = r - v;
        p_q[m65x_pkg::FLAG_C] = (r >= v);
        p_q[m65x_pkg::FLAG_Z] = (r == v);
        p_q[m65x_pkg::FLAG_N] = d[7];
    endfunction

    // kind: 0 shift left, 1 shift right, 2 rotate left, 3 rotate right
    function logic [7:0] shift(int kind, logic [7:0] v);
        logic [7:0] r;
        logic c;
        case (kind)
            0: begin c = v[7]; r = {v[6:0], 1'b0}; end
            1: begin c = v[0]; r = {1'b0, v[7:1]}; end
            2: begin c = v[7]; r = {v[6:0], p_q[m65x_pkg::FLAG_C]}; end
            default: begin c = v[0]; r = {p_q[m65x_pkg::FLAG_C], v[7:1]}; end
        endcase
        p_q[m65x_pkg::FLAG_C] = c;
        put_nz(r);
        return r;
    endfunction

    function void branch(logic take, logic [7:0] off);
        if (take) pc_q = pc_q + {{8{off[7]}}, off};
    endfunction

    function void note_input(m65x_pkg::t_in_word w);
        m65x_pkg::t_out_word o;
        logic [7:0]  v, wd;
        logic [15:0] t;
        logic        we;
        v = w.operand_value; we = 1'b0; wd = 8'h00;
        pc_q = pc_q + 16'(w.instr_length);
        case (m65x_pkg::t_cmd'(w.command))
            m65x_pkg::CMD_LDA: begin a_q = v; put_nz(v); end
            m65x_pkg::CMD_LDX: begin x_q = v; put_nz(v); end
            m65x_pkg::CMD_LDY: begin y_q = v; put_nz(v); end
            m65x_pkg::CMD_STA: begin we = 1'b1; wd = a_q; end
            m65x_pkg::CMD_STX: begin we = 1'b1; wd = x_q; end
            m65x_pkg::CMD_STY: begin we = 1'b1; wd = y_q; end
            m65x_pkg::CMD_TAX: begin x_q = a_q; put_nz(x_q); end
            m65x_pkg::CMD_TXA: begin a_q = x_q; put_nz(a_q); end
            m65x_pkg::CMD_TAY: begin y_q = a_q; put_nz(y_q); end
            m65x_pkg::CMD_TYA: begin a_q = y_q; put_nz(a_q); end
            m65x_pkg::CMD_TSX: begin x_q = sp_q; put_nz(x_q); end
            m65x_pkg::CMD_TXS: sp_q = x_q;
            m65x_pkg::CMD_PHA: push(a_q);
            m65x_pkg::CMD_PLA: begin a_q = pop(); put_nz(a_q); end
            m65x_pkg::CMD_PHP: push(p_q | 8'h30);
            m65x_pkg::CMD_PLP: begin
                p_q = pop();
                p_q[m65x_pkg::FLAG_B] = 1'b0;
                p_q[m65x_pkg::FLAG_U] = 1'b1;
            end
            m65x_pkg::CMD_CLC: p_q[m65x_pkg::FLAG_C] = 1'b0;
            m65x_pkg::CMD_SEC: p_q[m65x_pkg::FLAG_C] = 1'b1;
            m65x_pkg::CMD_CLI: p_q[m65x_pkg::FLAG_I] = 1'b0;
            m65x_pkg::CMD_SEI: p_q[m65x_pkg::FLAG_I] = 1'b1;
            m65x_pkg::CMD_CLV: p_q[m65x_pkg::FLAG_V] = 1'b0;
            m65x_pkg::CMD_CLD: p_q[m65x_pkg::FLAG_D] = 1'b0;
            m65x_pkg::CMD_SED: p_q[m65x_pkg::FLAG_D] = 1'b1;
            m65x_pkg::CMD_INX: begin x_q = x_q + 8'd1; put_nz(x_q); end
            m65x_pkg::CMD_INY: begin y_q = y_q + 8'd1; put_nz(y_q); end
            m65x_pkg::CMD_DEX: begin x_q = x_q - 8'd1; put_nz(x_q); end
            m65x_pkg::CMD_DEY: begin y_q = y_q - 8'd1; put_nz(y_q); end
            m65x_pkg::CMD_INC: begin we = 1'b1; wd = v + 8'd1; put_nz(wd); end
            m65x_pkg::CMD_DEC: begin we = 1'b1; wd = v - 8'd1; put_nz(wd); end
            m65x_pkg::CMD_AND: begin a_q = a_q & v; put_nz(a_q); end
            m65x_pkg::CMD_ORA: begin a_q = a_q | v; put_nz(a_q); end
            m65x_pkg::CMD_EOR: begin a_q = a_q ^ v; put_nz(a_q); end
            m65x_pkg::CMD_ADC: add_with_carry(v);
            m65x_pkg::CMD_SBC: add_with_carry(~v);
            m65x_pkg::CMD_ASLA: a_q = shift(0, a_q);
            m65x_pkg::CMD_LSRA: a_q = shift(1, a_q);
            m65x_pkg::CMD_ROLA: a_q = shift(2, a_q);
            m65x_pkg::CMD_RORA: a_q = shift(3, a_q);
            m65x_pkg::CMD_ASLM: begin we = 1'b1; wd = shift(0, v); end
            m65x_pkg::CMD_LSRM: begin we = 1'b1; wd = shift(1, v); end
            m65x_pkg::CMD_ROLM: begin we = 1'b1; wd = shift(2, v); end
            m65x_pkg::CMD_RORM: begin we = 1'b1; wd = shift(3, v); end
            m65x_pkg::CMD_CMP: compare(a_q, v);
            m65x_pkg::CMD_CPX: compare(x_q, v);
            m65x_pkg::CMD_CPY: compare(y_q, v);
            m65x_pkg::CMD_BIT: begin
                p_q[m65x_pkg::FLAG_N] = v[7];
                p_q[m65x_pkg::FLAG_V] = v[6];
                p_q[m65x_pkg::FLAG_Z] = ((v & a_q) == 8'h00);
            end
            m65x_pkg::CMD_BCC: branch(!p_q[m65x_pkg::FLAG_C], v);
            m65x_pkg::CMD_BCS: branch(p_q[m65x_pkg::FLAG_C], v);
            m65x_pkg::CMD_BEQ: branch(p_q[m65x_pkg::FLAG_Z], v);
            m65x_pkg::CMD_BNE: branch(!p_q[m65x_pkg::FLAG_Z], v);
            m65x_pkg::CMD_BMI: branch(p_q[m65x_pkg::FLAG_N], v);
            m65x_pkg::CMD_BPL: branch(!p_q[m65x_pkg::FLAG_N], v);
            m65x_pkg::CMD_BVC: branch(!p_q[m65x_pkg::FLAG_V], v);
            m65x_pkg::CMD_BVS: branch(p_q[m65x_pkg::FLAG_V], v);
            m65x_pkg::CMD_JMP: pc_q = w.operand_address;
            m65x_pkg::CMD_JSR: begin
                t = pc_q - 16'd1;
                push(t[15:8]);
                push(t[7:0]);
                pc_q = w.operand_address;
            end
            m65x_pkg::CMD_RTS: begin
                t[7:0] = pop();
                t[15:8] = pop();
                pc_q = t + 16'd1;
            end
            default: ;
        endcase
        o.write_enable    = we;
        o.write_address   = we ? w.operand_address : 16'h0000;
        o.write_data      = we ? wd : 8'h00;
        o.accumulator     = a_q;
        o.index_x         = x_q;
        o.index_y         = y_q;
        o.stack_pointer   = sp_q;
        o.program_counter = pc_q;
        o.status_flags    = p_q;
        pending.push_back(o);
    endfunction

    function void check_result(m65x_pkg::t_out_word got);
        m65x_pkg::t_out_word e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            n_err++;
            return;
        end
        e = pending.pop_front();
        if (got.write_enable !== e.write_enable)
            report("write_enable", 16'(e.write_enable), 16'(got.write_enable));
        if (got.write_address !== e.write_address)
            report("write_address", e.write_address, got.write_address);
        if (got.write_data !== e.write_data)
            report("write_data", 16'(e.write_data), 16'(got.write_data));
        if (got.accumulator !== e.accumulator)
            report("accumulator", 16'(e.accumulator), 16'(got.accumulator));
        if (got.index_x !== e.index_x)
            report("index_x", 16'(e.index_x), 16'(got.index_x));
        if (got.index_y !== e.index_y)
            report("index_y", 16'(e.index_y), 16'(got.index_y));
        if (got.stack_pointer !== e.stack_pointer)
            report("stack_pointer", 16'(e.stack_pointer), 16'(got.stack_pointer));
        if (got.program_counter !== e.program_counter)
            report("program_counter", e.program_counter, got.program_counter);
        if (got.status_flags !== e.status_flags)
            report("status_flags", 16'(e.status_flags), 16'(got.status_flags));
    endfunction

    function void report(string field, logic [15:0] e, logic [15:0] g);
        $display("%0t: %s expected %h actual %h", $time, field, e, g);
        n_err++;
    endfunction
endclass

module mos6502_execute_unit_tb;
    localparam int TIMEOUT_CYCLES = 200000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    m65x_pkg::t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    m65x_pkg::t_out_word o_out_data;

    exec_scoreboard sb;
    int  cycle_count = 0;
    int  hold_cycles = 0;

    mos6502_execute_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Both handshakes are sampled at the edge, before the driving processes update.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_input(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    // Receiver: random stalls per word, plus one long hold-off so the unit backs up.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
                @(posedge i_clk);
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
                if ($urandom_range(0, 9) < 4) gap = 0;
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                @(posedge i_clk iff o_out_valid);
            end
        end
    end

    task automatic send_word(logic [5:0] cmd, logic [7:0] v, logic [15:0] addr,
                             logic [1:0] len, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{command: cmd, operand_value: v, operand_address: addr,
                        instr_length: len};
        @(posedge i_clk iff o_in_ready);
    endtask

    function automatic int pick_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 13);
    endfunction

    initial begin
        int  k;
        bit  burst;
        logic [5:0] c;
        sb = new();
        sb.clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, stack round trips, flag edge cases.
        send_word(m65x_pkg::CMD_LDA, 8'hFF, 16'hFFFF, 2'd3, 0);
        send_word(m65x_pkg::CMD_ADC, 8'h01, 16'h0000, 2'd2, 0);
        send_word(m65x_pkg::CMD_LDA, 8'h7F, 16'h0000, 2'd2, 0);
        send_word(m65x_pkg::CMD_ADC, 8'h01, 16'h0000, 2'd2, 1);
        send_word(m65x_pkg::CMD_SBC, 8'hFF, 16'h0000, 2'd2, 0);
        send_word(m65x_pkg::CMD_LDY, 8'h80, 16'h0000, 2'd2, 0);
        send_word(m65x_pkg::CMD_TYA, 8'h00, 16'h0000, 2'd1, 0);
        send_word(m65x_pkg::CMD_PHP, 8'h00, 16'h0000, 2'd1, 0);
        send_word(m65x_pkg::CMD_PLP, 8'h00, 16'h0000, 2'd1, 0);
        send_word(m65x_pkg::CMD_ASLA, 8'h00, 16'h0000, 2'd1, 0);
        send_word(m65x_pkg::CMD_RORM, 8'h01, 16'hA5A5, 2'd3, 0);
        send_word(m65x_pkg::CMD_JSR, 8'h00, 16'h1234, 2'd3, 0);
        send_word(m65x_pkg::CMD_RTS, 8'h00, 16'h0000, 2'd1, 0);
        send_word(m65x_pkg::CMD_BNE, 8'h80, 16'h0000, 2'd2, 0);
        send_word(m65x_pkg::CMD_BEQ, 8'h7F, 16'h0000, 2'd2, 0);
        send_word(m65x_pkg::CMD_STA, 8'h00, 16'h5A5A, 2'd0, 0);
        send_word(m65x_pkg::CMD_BIT, 8'hC0, 16'h0000, 2'd2, 0);
        send_word(m65x_pkg::CMD_LDX, 8'h00, 16'h0000, 2'd2, 0);
        send_word(m65x_pkg::CMD_TXS, 8'h00, 16'h0000, 2'd1, 0);
        send_word(m65x_pkg::CMD_PLA, 8'h00, 16'h0000, 2'd1, 0);
        send_word(6'd63, 8'h00, 16'h0000, 2'd1, 0);

        // Random: most words are any command; a share are stack pairs so pops
        // return recently pushed data rather than only reset zeros.
        for (k = 0; k < 1300; k++) begin
            if (k == 400) hold_cycles = 60;
            burst = (k % 200) < 40;
            if ($urandom_range(0, 9) == 0) begin
                send_word(m65x_pkg::CMD_JSR, 8'($urandom), 16'($urandom), 2'($urandom),
                          pick_gap(burst));
                send_word(($urandom_range(0, 1) != 0) ? m65x_pkg::CMD_RTS
                                                      : m65x_pkg::CMD_PLA,
                          8'($urandom), 16'($urandom), 2'($urandom), pick_gap(burst));
            end else begin
                c = 6'($urandom_range(0, 63));
                send_word(c, 8'($urandom), 16'($urandom), 2'($urandom), pick_gap(burst));
            end
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk iff sb.pending.size() == 0);
        repeat (20) @(posedge i_clk);
        if (sb.n_err == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/m65x_pkg.sv
hdl/m65x_ram.sv
hdl/mos6502_execute_unit.sv
tb/mos6502_execute_unit_tb.sv
